[rtl/hqst_pkg.sv]
// ----------------------------------------------------------------------------
// hqst_pkg: shared definitions for the hall quadrature speed trim
// defaults, register indexes, hall codes and the divider status bundle
// ----------------------------------------------------------------------------
package hqst_pkg;

    // parameter defaults
    localparam int TIME_WIDTH_DEF     = 32;
    localparam int COUNT_WIDTH_DEF    = 16;
    localparam int DUTY_FRAC_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERTED     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_TARGET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DUTY = 2'd2;

    // hall sensor codes, bit1 first sensor, bit0 second sensor
    localparam logic [1:0] HALL_LL = 2'b00;
    localparam logic [1:0] HALL_LH = 2'b01;
    localparam logic [1:0] HALL_HL = 2'b10;
    localparam logic [1:0] HALL_HH = 2'b11;

    // timestamp slots
    localparam logic [1:0] STAMP_T00 = 2'd0;
    localparam logic [1:0] STAMP_T10 = 2'd1;
    localparam logic [1:0] STAMP_T01 = 2'd2;
    localparam logic [1:0] STAMP_T11 = 2'd3;

    // status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

[rtl/hqst_div.sv]
// ----------------------------------------------------------------------------
// hqst_div: bit-serial restoring divider
// one quotient bit per clock, done pulses for one cycle after the last bit
// ----------------------------------------------------------------------------
module hqst_div #(
    parameter int QW = 27,
    parameter int HW = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [QW-1:0]         i_dividend,
    input  logic [HW-1:0]         i_divisor,
    output hqst_pkg::t_div_status o_sts,
    output logic [QW-1:0]         o_quot
);
    import hqst_pkg::*;

    localparam int CNT_W = $clog2(QW);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [HW-1:0]    r_rem, n_rem;
    logic [QW-1:0]    r_dvd, n_dvd;
    logic [HW-1:0]    r_dsr, n_dsr;
    logic [QW-1:0]    r_quot, n_quot;

    logic [HW:0]      w_trial;
    logic [HW:0]      w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(QW - 1);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[HW-1:0] : w_trial[HW-1:0];
            n_quot = {r_quot[QW-2:0], w_ge};
            n_dvd  = {r_dvd[QW-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_dsr  <= n_dsr;
        r_quot <= n_quot;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

[rtl/hall_quadrature_speed_trim.sv]
// ----------------------------------------------------------------------------
// hall_quadrature_speed_trim: speed trim for one motor channel
// follows the quadrature hall sequence, times a full cycle and nudges the
// drive duty by 0.1 - 1602.564/S, S the summed span, clamped to [0.05, 1]
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     word
//  -------   ---  ----------------------------  ------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: hall_state, direction,
//                                               time_us; tuser: action
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: duty, pulse_count;
//                                               tlast: run_done
//  cfg       in   i_cfg_valid/o_cfg_ready       index + data, always ready
//
//  a sample that does not close a hall cycle is taken and the input stays
//  ready; a start word passes through the emit state, a cycle close through
//  the span, divider start, divider run, trim and emit states (a zero span
//  skips the divider run), the serial divider making one quotient bit per
//  clock; a stall on the output lengthens both by the stall
//  the result sits in an output register, so a new word is taken while the
//  previous result is still waiting; a stalled output holds only a pending new result in the emit state
//  synchronous active-low reset clears control state; timestamps are not reset
//
module hall_quadrature_speed_trim #(
    parameter int TIME_WIDTH     = hqst_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH    = hqst_pkg::COUNT_WIDTH_DEF,
    parameter int DUTY_FRAC_BITS = hqst_pkg::DUTY_FRAC_BITS_DEF,
    localparam int DW          = DUTY_FRAC_BITS + 1,
    localparam int IN_TDATA_W  = ((TIME_WIDTH + 3 + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((DW + COUNT_WIDTH + 7) / 8) * 8,
    localparam int CFG_DATA_W  = (COUNT_WIDTH > DW) ? COUNT_WIDTH : DW
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // hall_state [1:0], direction [2], time_us [TIME_WIDTH+2:3], zero pad above
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,
    // action: 0 hall sample, 1 start a new run
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // duty [DW-1:0], pulse_count [DW+COUNT_WIDTH-1:DW], zero pad above
    output logic [OUT_TDATA_W-1:0]             m_axis_tdata,
    // run_done
    output logic                               m_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hqst_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]              i_cfg_data
);
    import hqst_pkg::*;

    // span: sum of two half-period differences, one bit wider for the carry of the sum
    localparam int HW = TIME_WIDTH + 1;

    // duty constants in Q1.F
    localparam longint unsigned ONE_L   = 64'd1 << DUTY_FRAC_BITS;
    localparam longint unsigned TENTH_L = (ONE_L + 64'd5) / 64'd10;
    localparam longint unsigned FLOOR_L = (ONE_L * 64'd5 + 64'd50) / 64'd100;
    // floor(10^6 * 2^F / (624 * h)) == floor(TERM_K / h)
    localparam longint unsigned TERM_NUM = 64'd1000000 << DUTY_FRAC_BITS;
    localparam longint unsigned TERM_K_L = TERM_NUM / 64'd624;
    localparam int QW = $clog2(TERM_K_L + 64'd1);
    localparam int SW = QW + 2;

    localparam logic [DW-1:0] DUTY_ONE   = DW'(ONE_L);
    localparam logic [DW-1:0] DUTY_FLOOR = DW'(FLOOR_L);
    localparam logic [DW-1:0] DUTY_RST   = DW'(ONE_L >> 1);
    localparam logic [QW-1:0] TERM_K     = QW'(TERM_K_L);
    localparam logic [SW-1:0] TENTH_S    = SW'(TENTH_L);
    localparam logic [SW-1:0] ONE_S      = SW'(ONE_L);
    localparam logic [SW-1:0] FLOOR_S    = SW'(FLOOR_L);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SPAN   = 3'd1;
    localparam logic [2:0] ST_DIVGO  = 3'd2;
    localparam logic [2:0] ST_DIVRUN = 3'd3;
    localparam logic [2:0] ST_TRIM   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    // configuration
    logic                   r_inverted, n_inverted;
    logic [COUNT_WIDTH-1:0] r_target, n_target;
    logic [DW-1:0]          r_init_duty, n_init_duty;

    // run state
    logic [2:0]             r_state, n_state;
    logic [1:0]             r_phase, n_phase;
    logic [DW-1:0]          r_duty, n_duty;
    logic [COUNT_WIDTH-1:0] r_cycles, n_cycles;
    logic                   r_running, n_running;
    logic                   r_last, n_last;
    logic [HW-1:0]          r_span, n_span;
    logic [TIME_WIDTH-1:0]  r_stamp [4];

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [DW-1:0]          r_out_duty;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic                   r_out_last;

    // input word fields
    logic [1:0]             w_hs;
    logic                   w_rev;
    logic [TIME_WIDTH-1:0]  w_time;
    logic [1:0]             w_s1, w_s3;
    logic                   w_slot_vld;
    logic [1:0]             w_slot;
    logic                   w_in_acc;
    logic                   w_stamp_we;
    logic                   w_out_load;

    // trim datapath
    logic [TIME_WIDTH-1:0]  w_d1, w_d2;
    logic                   w_div_start;
    t_div_status            w_div_sts;
    logic [QW-1:0]          w_quot;
    logic [SW-1:0]          w_sum;
    logic [DW-1:0]          w_trim;
    logic [COUNT_WIDTH-1:0] w_cycles_inc;

    assign w_hs   = s_axis_tdata[1:0];
    assign w_rev  = s_axis_tdata[2] ^ r_inverted;
    assign w_time = s_axis_tdata[3 +: TIME_WIDTH];

    // expected order: forward 0-1-3-2-0, reverse 0-2-3-1-0
    assign w_s1 = w_rev ? HALL_HL : HALL_LH;
    assign w_s3 = w_rev ? HALL_LH : HALL_HL;

    always_comb begin
        w_slot_vld = 1'b1;
        w_slot     = STAMP_T00;
        if (r_phase == HALL_LL && w_hs == w_s1) begin
            w_slot = STAMP_T00;
        end else if (r_phase == w_s1 && w_hs == HALL_HH) begin
            w_slot = STAMP_T10;
        end else if (r_phase == HALL_HH && w_hs == w_s3) begin
            w_slot = STAMP_T01;
        end else if (r_phase == w_s3 && w_hs == HALL_LL) begin
            w_slot = STAMP_T11;
        end else begin
            w_slot_vld = 1'b0;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_stamp_we    = w_in_acc & ~s_axis_tuser & r_running & w_slot_vld;

    // wrap-around differences; the sum keeps its carry
    assign w_d1 = r_stamp[STAMP_T01] - r_stamp[STAMP_T00];
    assign w_d2 = r_stamp[STAMP_T11] - r_stamp[STAMP_T10];

    // zero span skips the divider and lands on the floor
    assign w_div_start = (r_state == ST_DIVGO) && (r_span != '0);

    hqst_div #(
        .QW (QW),
        .HW (HW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (TERM_K),
        .i_divisor  (r_span),
        .o_sts      (w_div_sts),
        .o_quot     (w_quot)
    );

    // duty + tenth - term, signed, then clamp
    assign w_sum = {{(SW-DW){1'b0}}, r_duty} + TENTH_S - {{(SW-QW){1'b0}}, w_quot};

    always_comb begin
        if (r_span == '0) begin
            w_trim = DUTY_FLOOR;
        end else if ($signed(w_sum) > $signed(ONE_S)) begin
            w_trim = DUTY_ONE;
        end else if ($signed(w_sum) < $signed(FLOOR_S)) begin
            w_trim = DUTY_FLOOR;
        end else begin
            w_trim = w_sum[DW-1:0];
        end
    end

    // saturating cycle count
    assign w_cycles_inc = (r_cycles < COUNT_MAX) ? r_cycles + 1'b1 : r_cycles;

    assign w_out_load = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_inverted  = r_inverted;
        n_target    = r_target;
        n_init_duty = r_init_duty;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INVERTED:     n_inverted  = i_cfg_data[0];
                CFG_PULSE_TARGET: n_target    = i_cfg_data[COUNT_WIDTH-1:0];
                CFG_INITIAL_DUTY: n_init_duty = i_cfg_data[DW-1:0];
                default:          ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_duty    = r_duty;
        n_cycles  = r_cycles;
        n_running = r_running;
        n_last    = r_last;
        n_span    = r_span;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && s_axis_tuser) begin
                    // start of a run
                    n_duty    = (r_init_duty > DUTY_ONE) ? DUTY_ONE : r_init_duty;
                    n_cycles  = '0;
                    n_phase   = HALL_LL;
                    n_last    = (r_target == '0);
                    n_running = (r_target != '0);
                    n_state   = ST_EMIT;
                end else if (w_stamp_we) begin
                    n_phase = w_hs;
                    if (w_slot == STAMP_T11) begin
                        n_state = ST_SPAN;
                    end
                end
            end
            ST_SPAN: begin
                n_span  = {1'b0, w_d1} + {1'b0, w_d2};
                n_state = ST_DIVGO;
            end
            ST_DIVGO: begin
                n_state = (r_span == '0) ? ST_TRIM : ST_DIVRUN;
            end
            ST_DIVRUN: begin
                if (w_div_sts.done) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                n_duty   = w_trim;
                n_cycles = w_cycles_inc;
                n_last   = (w_cycles_inc >= r_target);
                if (w_cycles_inc >= r_target) begin
                    n_running = 1'b0;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverted  <= 1'b0;
            r_target    <= '0;
            r_init_duty <= DUTY_RST;
            r_state     <= ST_IDLE;
            r_phase     <= HALL_LL;
            r_duty      <= DUTY_RST;
            r_cycles    <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inverted  <= n_inverted;
            r_target    <= n_target;
            r_init_duty <= n_init_duty;
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_duty      <= n_duty;
            r_cycles    <= n_cycles;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_span <= n_span;
        if (w_stamp_we) begin
            r_stamp[w_slot] <= w_time;
        end
        if (w_out_load) begin
            r_out_duty  <= r_duty;
            r_out_count <= r_cycles;
            r_out_last  <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W-DW-COUNT_WIDTH){1'b0}}, r_out_count, r_out_duty};

endmodule

[rtl/hqst_checker.sv]
// ----------------------------------------------------------------------------
// hqst_checker: port-level checks for the hall quadrature speed trim
// attached to every instance of the top level by the bind below
// ----------------------------------------------------------------------------
module hqst_checker #(
    parameter int TIME_WIDTH     = hqst_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH    = hqst_pkg::COUNT_WIDTH_DEF,
    parameter int DUTY_FRAC_BITS = hqst_pkg::DUTY_FRAC_BITS_DEF,
    localparam int DW          = DUTY_FRAC_BITS + 1,
    localparam int IN_TDATA_W  = ((TIME_WIDTH + 3 + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((DW + COUNT_WIDTH + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   s_axis_tuser,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready
);
    import hqst_pkg::*;

    localparam logic [DW-1:0] DUTY_ONE = DW'(64'd1 << DUTY_FRAC_BITS);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed under stall");

    // a start word always produces a result before the next word is taken
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input taken right after a start word");

    // duty never exceeds full scale
    a_duty_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DW-1:0] <= DUTY_ONE)
        else $error("duty above full scale");

endmodule

bind hall_quadrature_speed_trim hqst_checker #(
    .TIME_WIDTH     (TIME_WIDTH),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
) u_hqst_checker (.*);
